// ----- rtl/core/lbp_pkg.sv -----
// Shared types and constants for the 3x3 local binary pattern stream block.
package lbp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Widths, dimension minimum and configuration register indices
  localparam int DIM_W   = 11;
  localparam int PIX_W   = 8;
  localparam int CODE_W  = 8;
  localparam int DIM_MIN = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position flags of one accepted pixel
  typedef struct packed {
    logic emit;       // centre is an interior pixel, a code is due
    logic row_end;    // last code of an output row
    logic frame_end;  // last code of the output frame
  } pos_info_t;

  // One column of the window: top, middle, bottom pixel
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

  // Line store entry: older row above newer row
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_entry_t;

endpackage

// ----- rtl/core/lbp_line_mem.sv -----
// Line store memory: one write port, one registered read port.
module lbp_line_mem #(
  parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Old data on a same-address read and write; caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/lbp_pos_ctrl.sv -----
// Column and row counters with dimension clamping and frame restart.
module lbp_pos_ctrl #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     frame_start,
  input  logic [lbp_pkg::DIM_W-1:0] frame_width,
  input  logic [lbp_pkg::DIM_W-1:0] frame_height,
  output logic [CW-1:0]            col,
  output lbp_pkg::pos_info_t       info
);
  import lbp_pkg::*;

  localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int RMPW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

  logic [CW-1:0]   column_count;
  logic [RW-1:0]   row_count;
  logic [RW-1:0]   row;
  logic [CMPW-1:0] w_eff;
  logic [RMPW-1:0] h_eff;
  logic            last_col;
  logic            last_row;

  // Saturate registers into [3, MAX]
  always_comb begin
    if (CMPW'(frame_width) < CMPW'(DIM_MIN)) begin
      w_eff = CMPW'(DIM_MIN);
    end else if (CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(frame_width);
    end
    if (RMPW'(frame_height) < RMPW'(DIM_MIN)) begin
      h_eff = RMPW'(DIM_MIN);
    end else if (RMPW'(frame_height) > RMPW'(MAX_HEIGHT)) begin
      h_eff = RMPW'(MAX_HEIGHT);
    end else begin
      h_eff = RMPW'(frame_height);
    end
  end

  always_comb begin
    col      = frame_start ? '0 : column_count;
    row      = frame_start ? '0 : row_count;
    last_col = (CMPW'(col) + CMPW'(1)) >= w_eff;
    last_row = (RMPW'(row) + RMPW'(1)) >= h_eff;
    info.emit      = (CMPW'(col) >= CMPW'(2)) && (RMPW'(row) >= RMPW'(2));
    info.row_end   = last_col;
    info.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row + RW'(1);
      end else begin
        column_count <= col + CW'(1);
        row_count    <= row;
      end
    end
  end

endmodule

// ----- rtl/core/lbp_code_unit.sv -----
// Two-column window register and the eight neighbor comparisons.
module lbp_code_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  lbp_pkg::win_col_t         new_col,
  output logic [lbp_pkg::CODE_W-1:0] code
);
  import lbp_pkg::*;

  win_col_t c1;  // previous column
  win_col_t c2;  // column before that
  logic [PIX_W-1:0] centre;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
    end else if (shift) begin
      c2 <= c1;
      c1 <= new_col;
    end
  end

  always_comb begin
    centre  = c1.mid;
    code[7] = c2.top      > centre;
    code[6] = c1.top      > centre;
    code[5] = new_col.top > centre;
    code[4] = new_col.mid > centre;
    code[3] = new_col.bot > centre;
    code[2] = c1.bot      > centre;
    code[1] = c2.bot      > centre;
    code[0] = c2.mid      > centre;
  end

endmodule

// ----- rtl/core/lbp_3x3_stream.sv -----
// Streaming 3x3 local binary pattern: top level with line store pipeline.
//
// Usage:
//   s_axis_*  : gray pixels in raster order, tdata[7:0] = pixel,
//               tuser = frame_start (restarts the column and row counters).
//   m_axis_*  : one item per interior pixel, tdata[7:0] = pattern code
//               (bit7 top-left clockwise to bit0 left, set when neighbor >
//               centre), tuser = row_end, tlast = frame_end.
//   cfg_*     : register writes, index 0 frame_width, 1 frame_height; values
//               saturate to [3, MAX]. Write only while the block is idle.
// Throughput: one pixel per clock unless the output stalls. The code of the
//   pixel that completes a window forms in stage 1, then enters the output register.
//   The line store is one memory of {upper, middle} rows, read at accept
//   and written back one stage later; a back-to-back hit on the same
//   column is forwarded.
// Reset: counters, window and valids clear; line store contents are not
//   cleared, unwritten entries only reach pixels that make no code.
// Stall: when m_axis_tready is low the output register holds; pixels that
//   make no code still pass stage 1, the first one that makes a code waits
//   there and s_axis_tready drops until the output register frees.
module lbp_3x3_stream #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // pixel input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] pixel
  input  logic                      s_axis_tuser,   // [0] frame_start
  // code output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] pattern_code
  output logic                      m_axis_tuser,   // [0] row_end
  output logic                      m_axis_tlast,   // frame_end
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [lbp_pkg::DIM_W-1:0] cfg_data
);
  import lbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = $bits(line_entry_t);

  // Configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(160);
      frame_height <= DIM_W'(120);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: position and line store read
  logic          accept;
  logic [CW-1:0] col0;
  pos_info_t     info0;

  lbp_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_start  (s_axis_tuser),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (col0),
    .info         (info0)
  );

  // Stage 1 registers
  logic             valid1;
  logic [CW-1:0]    col1;
  logic [PIX_W-1:0] pix1;
  pos_info_t        info1;
  logic             fwd_hit;   // stage 1 wrote this column on the read edge
  line_entry_t      fwd_entry;
  logic [EW-1:0]    mem_rdata;
  line_entry_t      rd_eff;
  line_entry_t      wr_entry;
  win_col_t         new_col1;
  logic             s1_adv;
  logic             out_free;
  logic [CODE_W-1:0] code1;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = valid1 && (!info1.emit || out_free);
  assign s_axis_tready = !valid1 || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rd_eff            = fwd_hit ? fwd_entry : line_entry_t'(mem_rdata);
  assign wr_entry.upper    = rd_eff.middle;
  assign wr_entry.middle   = pix1;

  assign new_col1.top = rd_eff.upper;
  assign new_col1.mid = rd_eff.middle;
  assign new_col1.bot = pix1;

  lbp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (EW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col0),
    .rd_data (mem_rdata),
    .wr_en   (s1_adv),
    .wr_addr (col1),
    .wr_data (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= 1'b1;
    end else if (s1_adv) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col1      <= col0;
      pix1      <= s_axis_tdata;
      info1     <= info0;
      fwd_hit   <= s1_adv && (col1 == col0);
      fwd_entry <= wr_entry;
    end
  end

  lbp_code_unit u_code (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .new_col (new_col1),
    .code    (code1)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && info1.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && info1.emit) begin
      m_axis_tdata <= code1;
      m_axis_tuser <= info1.row_end;
      m_axis_tlast <= info1.frame_end;
    end
  end

  // Checks
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tlast || m_axis_tuser))
    else $error("frame_end without row_end");

  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (valid1 && info1.emit && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked code");

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && info1.emit) |=> m_axis_tvalid)
    else $error("advancing code lost before output register");

  a_forward_only_after_write: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_adv && (col1 == col0)) |=> (valid1 && fwd_hit))
    else $error("same-column hit not forwarded");

endmodule
